>>> rtl/kct_pkg.sv
// ---------------------------------------------------------------------------
// kct_pkg: shared types and constants for the keypad countdown timer
// Request and result payload structs, event codes and BCD helpers.
// ---------------------------------------------------------------------------
package kct_pkg;

  localparam int NUM_DIGITS = 8;
  localparam int DIGIT_W    = 4;
  localparam int COUNT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;
  localparam logic [COUNT_W-1:0] END_COUNT  = 4'd1;

  // BCD pair constants
  localparam logic [7:0] PAIR_MAX_59 = 8'h59;
  localparam logic [7:0] PAIR_MAX_99 = 8'h99;
  localparam logic [DIGIT_W-1:0] TENS_LIMIT = 4'd6;

  // event codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_DIGIT = 2'd0,
    MODE_START = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [DIGIT_W-1:0] key_digit;
  } in_t;

  typedef struct packed {
    logic [BCD_W-1:0]   display_bcd;
    logic [COUNT_W-1:0] shown_digits;
    logic               relay_on;
    logic               running;
    logic               halted;
  } out_t;

  // decrement a nonzero two-digit BCD value
  function automatic logic [7:0] bcd_pair_dec(input logic [7:0] v);
    logic [7:0] r;
    if (v[3:0] != 4'd0) begin
      r = {v[7:4], v[3:0] - 4'd1};
    end else begin
      r = {v[7:4] - 4'd1, DIGIT_MAX};
    end
    return r;
  endfunction

  // limit a two-digit BCD value to 59
  function automatic logic [7:0] bcd_pair_clamp59(input logic [7:0] v);
    logic [7:0] r;
    if (v[7:4] >= TENS_LIMIT) begin
      r = PAIR_MAX_59;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/kct_countdown.sv
// ---------------------------------------------------------------------------
// kct_countdown: one-centisecond BCD decrement of hh:mm:ss:cc
// Borrows from centiseconds through seconds and minutes into hours.
// ---------------------------------------------------------------------------
module kct_countdown (
  input  logic [kct_pkg::BCD_W-1:0] time_bcd,
  output logic [kct_pkg::BCD_W-1:0] time_dec,
  output logic                      at_zero
);
  import kct_pkg::*;

  logic [7:0] cs;
  logic [7:0] ss;
  logic [7:0] mm;
  logic [7:0] hh;
  logic [7:0] cs_dec;
  logic [7:0] ss_dec;
  logic [7:0] mm_dec;
  logic [7:0] hh_dec;

  assign cs = time_bcd[7:0];
  assign ss = time_bcd[15:8];
  assign mm = time_bcd[23:16];
  assign hh = time_bcd[31:24];

  assign at_zero = (time_bcd == '0);

  // borrow chain through the fields
  always_comb begin
    cs_dec = cs;
    ss_dec = ss;
    mm_dec = mm;
    hh_dec = hh;
    if (cs != 8'h00) begin
      cs_dec = bcd_pair_dec(cs);
    end else begin
      cs_dec = PAIR_MAX_99;
      if (ss != 8'h00) begin
        ss_dec = bcd_pair_dec(ss);
      end else begin
        ss_dec = PAIR_MAX_59;
        if (mm != 8'h00) begin
          mm_dec = bcd_pair_dec(mm);
        end else begin
          mm_dec = PAIR_MAX_59;
          if (hh != 8'h00) begin
            hh_dec = bcd_pair_dec(hh);
          end
        end
      end
    end
  end

  assign time_dec = {hh_dec, mm_dec, ss_dec, cs_dec};

endmodule

>>> rtl/kct_core.sv
// ---------------------------------------------------------------------------
// kct_core: timer state and per-request update
// Holds the digit store, countdown time and status flags, applies one
// request per step and presents the resulting display and status.
// ---------------------------------------------------------------------------
module kct_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  kct_pkg::in_t  req,
  output kct_pkg::out_t result
);
  import kct_pkg::*;

  logic [BCD_W-1:0]   store_r,   store_nxt;
  logic [COUNT_W-1:0] count_r,   count_nxt;
  logic [BCD_W-1:0]   time_r,    time_nxt;
  logic [COUNT_W-1:0] run_cnt_r, run_cnt_nxt;
  logic               active_r,  active_nxt;
  logic               pause_r,   pause_nxt;
  logic               relay_r,   relay_nxt;
  logic               fresh_r,   fresh_nxt;

  logic [BCD_W-1:0]   time_dec;
  logic               at_zero;
  logic [BCD_W-1:0]   base_store;
  logic [COUNT_W-1:0] base_count;
  mode_t              mode;

  assign mode = mode_t'(req.mode);

  kct_countdown u_countdown (
    .time_bcd (time_r),
    .time_dec (time_dec),
    .at_zero  (at_zero)
  );

  // store as seen by a digit key, emptied after a countdown end
  assign base_store = fresh_r ? '0 : store_r;
  assign base_count = fresh_r ? '0 : count_r;

  // next state
  always_comb begin
    store_nxt   = store_r;
    count_nxt   = count_r;
    time_nxt    = time_r;
    run_cnt_nxt = run_cnt_r;
    active_nxt  = active_r;
    pause_nxt   = pause_r;
    relay_nxt   = relay_r;
    fresh_nxt   = fresh_r;
    if (step) begin
      unique case (mode)
        MODE_DIGIT: begin
          if (!active_r && (req.key_digit <= DIGIT_MAX)) begin
            fresh_nxt = 1'b0;
            store_nxt = base_store;
            count_nxt = base_count;
            if (base_count < FULL_COUNT) begin
              store_nxt = {base_store[BCD_W-DIGIT_W-1:0], req.key_digit};
              count_nxt = base_count + 4'd1;
            end
          end
        end
        MODE_START: begin
          if (!active_r && (count_r != '0)) begin
            time_nxt = {store_r[31:24], bcd_pair_clamp59(store_r[23:16]),
                        bcd_pair_clamp59(store_r[15:8]), store_r[7:0]};
            run_cnt_nxt = count_r;
            active_nxt  = 1'b1;
            pause_nxt   = 1'b0;
            fresh_nxt   = 1'b0;
          end else if (active_r) begin
            pause_nxt = !pause_r;
          end
        end
        MODE_CLEAR: begin
          store_nxt   = '0;
          count_nxt   = '0;
          time_nxt    = '0;
          run_cnt_nxt = '0;
          active_nxt  = 1'b0;
          pause_nxt   = 1'b0;
          relay_nxt   = 1'b0;
          fresh_nxt   = 1'b0;
        end
        MODE_TICK: begin
          if (active_r && !pause_r) begin
            if (at_zero) begin
              relay_nxt   = !relay_r;
              active_nxt  = 1'b0;
              store_nxt   = '0;
              count_nxt   = END_COUNT;
              run_cnt_nxt = '0;
              fresh_nxt   = 1'b1;
            end else begin
              time_nxt  = time_dec;
              store_nxt = time_dec;
              count_nxt = run_cnt_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r   <= '0;
      count_r   <= '0;
      time_r    <= '0;
      run_cnt_r <= '0;
      active_r  <= 1'b0;
      pause_r   <= 1'b0;
      relay_r   <= 1'b0;
      fresh_r   <= 1'b0;
    end else begin
      store_r   <= store_nxt;
      count_r   <= count_nxt;
      time_r    <= time_nxt;
      run_cnt_r <= run_cnt_nxt;
      active_r  <= active_nxt;
      pause_r   <= pause_nxt;
      relay_r   <= relay_nxt;
      fresh_r   <= fresh_nxt;
    end
  end

  // result reflects the state after the request
  always_comb begin
    result.display_bcd  = store_nxt;
    result.shown_digits = count_nxt;
    result.relay_on     = relay_nxt;
    result.running      = active_nxt;
    result.halted       = pause_nxt;
  end

`ifndef ASSERT_OFF
  // digit count never exceeds the store size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= FULL_COUNT) && (run_cnt_r <= FULL_COUNT))
    else $error("digit count out of range");

  // pause only exists during a countdown
  a_pause_active: assert property (@(posedge clk) disable iff (!rst_n)
    pause_r |-> active_r)
    else $error("paused while not running");

  // fresh entry mark only after a countdown has stopped
  a_fresh_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r |-> !active_r)
    else $error("fresh entry set while running");

  // a clear request leaves the timer fully idle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (mode == MODE_CLEAR)) |=>
      (!active_r && !relay_r && (count_r == '0) && (store_r == '0)))
    else $error("clear did not reset timer state");
`endif

endmodule

>>> rtl/keypad_countdown_timer_top.sv
// ---------------------------------------------------------------------------
// keypad_countdown_timer_top: keypad-driven hh:mm:ss:cc countdown timer
// Request register, timer state update and result register.
// ---------------------------------------------------------------------------
// Takes one request (digit key, start/pause, clear or centisecond tick) per
// clock while the result side accepts, and returns exactly one result per
// request: the eight BCD display digits, the number of digits shown and the
// relay, running and paused bits after the request is applied. An accepted
// request passes through the request register and the state update into the
// result register before it reaches the result port; with the result side
// ready the block sustains one request every cycle.
module keypad_countdown_timer_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kct_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output kct_pkg::out_t out_data
);
  import kct_pkg::*;

  logic in_valid_r, in_valid_nxt;
  in_t  in_data_r;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  logic advance;
  logic step;
  out_t result;

  // pipeline moves when the result register is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign step     = in_valid_r && advance;

  assign in_valid_nxt  = in_ready ? in_valid : in_valid_r;
  assign out_valid_nxt = advance ? in_valid_r : out_valid_r;

  kct_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .req    (in_data_r),
    .result (result)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
